// File: rtl/lcg_fisher_yates_shuffler_top_defines.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef LCG_FISHER_YATES_SHUFFLER_TOP_DEFINES_SVH
`define LCG_FISHER_YATES_SHUFFLER_TOP_DEFINES_SVH

// same-cycle implication
`define LFYS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFYS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lfys_pkg.sv
`timescale 1ns / 1ps

package lfys_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SHUFFLE = 2'd1,
    OP_READ    = 2'd2
  } opcode_e;

  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;
  localparam int unsigned FRAC_BITS = 31;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  entry_addr;
    logic [15:0] entry_value;
    logic [10:0] count;
    logic [31:0] seed_in;
  } in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [31:0] seed_out;
  } out_t;

endpackage

// File: rtl/lfys_chan_if.sv
`timescale 1ns / 1ps

interface lfys_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lfys_ram.sv
`timescale 1ns / 1ps

module lfys_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lcg_fisher_yates_shuffler_top.sv
`timescale 1ns / 1ps
// Fisher-Yates shuffler over an index memory, driven by a 32-bit LCG.
// in_i carries one command per transaction: load entry, run shuffle or read
// entry. out_o returns exactly one transaction per command, in order:
// read_value (entry for a read, else zero) and seed_out (final generator
// seed for a shuffle, else seed_in echoed).
// Sequencing: load, read and an unused opcode pass from acceptance to the
// finish state, which presents the result. A shuffle of n entries (count
// saturated to DEPTH) runs n - 1 steps for n >= 2, else none, then finishes;
// each step is an LCG multiply, an index multiply and two reads and two
// writes of the single read/single write port index memory, which sets the
// step length. One command is in work at a time: a new one is taken only
// once the last has left the finish state; in_i.ready is high while idle.
// Reset clears the sequencer, the output register and the generator seed;
// the index memory is not cleared and holds nothing defined until loaded.
// When the receiver stalls, the result stays in the output register, one
// more command is accepted and run, and its result waits until the register
// frees up.
`include "lcg_fisher_yates_shuffler_top_defines.svh"

module lcg_fisher_yates_shuffler_top #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned ENTRY_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfys_chan_if.sink   in_i,
  lfys_chan_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = lfys_pkg::FRAC_BITS + AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LCG,
    S_MUL,
    S_RDJ,
    S_WRI,
    S_WRJ,
    S_FIN
  } state_e;

  state_e                 state_q;
  logic [1:0]             op_q;
  logic                   rd_ok_q;
  logic [31:0]            seed_q;
  logic [AW-1:0]          i_q;
  logic [AW-1:0]          j_q;
  logic [ENTRY_WIDTH-1:0] vi_q;
  logic                   out_valid_q;
  lfys_pkg::out_t         out_data_q;

  logic                   in_acc;
  logic                   addr_ok;
  logic [AW-1:0]          addr_idx;
  logic [CW-1:0]          n_sat;
  logic [PW-1:0]          prod;
  logic                   out_free;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign addr_ok    = 32'(in_i.data.entry_addr) < 32'(DEPTH);
  assign addr_idx   = AW'(in_i.data.entry_addr);
  assign n_sat      = (32'(in_i.data.count) > 32'(DEPTH)) ? CW'(DEPTH)
                                                          : CW'(in_i.data.count);
  assign prod       = PW'(seed_q[lfys_pkg::FRAC_BITS-1:0]) * PW'({1'b0, i_q} + 1'b1);
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && addr_ok) begin
          if (in_i.data.opcode == lfys_pkg::OP_LOAD) begin
            ram_we    = 1'b1;
            ram_waddr = addr_idx;
            ram_wdata = ENTRY_WIDTH'(in_i.data.entry_value);
          end
          if (in_i.data.opcode == lfys_pkg::OP_READ) begin
            ram_re    = 1'b1;
            ram_raddr = addr_idx;
          end
        end
      end
      S_LCG: begin
        ram_re    = 1'b1;
        ram_raddr = i_q;
      end
      S_RDJ: begin
        ram_re    = 1'b1;
        ram_raddr = j_q;
      end
      S_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      S_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = vi_q;
      end
      default: begin
      end
    endcase
  end

  lfys_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_index_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      rd_ok_q     <= 1'b0;
      seed_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      vi_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= in_i.data.opcode;
            rd_ok_q <= addr_ok;
            seed_q  <= in_i.data.seed_in;
            i_q     <= AW'(n_sat - CW'(1));
            if (in_i.data.opcode == lfys_pkg::OP_SHUFFLE && n_sat >= CW'(2)) begin
              state_q <= S_LCG;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_LCG: begin
          seed_q  <= seed_q * lfys_pkg::LCG_MUL + lfys_pkg::LCG_ADD;
          state_q <= S_MUL;
        end
        S_MUL: begin
          j_q     <= prod[lfys_pkg::FRAC_BITS +: AW];
          vi_q    <= ram_rdata;
          state_q <= S_RDJ;
        end
        S_RDJ: begin
          state_q <= S_WRI;
        end
        S_WRI: begin
          state_q <= S_WRJ;
        end
        S_WRJ: begin
          if (i_q == AW'(1)) begin
            state_q <= S_FIN;
          end else begin
            i_q     <= i_q - AW'(1);
            state_q <= S_LCG;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            out_data_q.seed_out <= seed_q;
            out_data_q.read_value <= (op_q == lfys_pkg::OP_READ && rd_ok_q)
                                     ? 16'(ram_rdata) : 16'd0;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // swap partner always lies at or below the current position
  `LFYS_ASSERT_NOW(a_j_in_range, state_q == S_RDJ, j_q <= i_q, "swap index beyond position")
  // a step never runs at position zero
  `LFYS_ASSERT_NOW(a_i_nonzero, state_q == S_LCG, i_q != '0, "shuffle step at position zero")
  // the last swap hands over to the result
  `LFYS_ASSERT_NEXT(a_last_step, state_q == S_WRJ && i_q == AW'(1), state_q == S_FIN,
                    "shuffle did not finish after last step")
  // a result appears only out of the finish state
  `LFYS_ASSERT_NEXT(a_result_src, !out_valid_q && state_q != S_FIN, !out_valid_q,
                    "result without finished command")

endmodule

// File: tb/sv/lcg_fisher_yates_shuffler_top_tb.sv
`timescale 1ns / 1ps

module lcg_fisher_yates_shuffler_top_tb;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned LOADED      = 256;
  localparam logic [31:0] SEED_MUL    = 32'd1103515245;
  localparam logic [31:0] SEED_INC    = 32'd12345;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned LONG_HOLD   = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lfys_chan_if #(.T(lfys_pkg::in_t))  cmd_if ();
  lfys_chan_if #(.T(lfys_pkg::out_t)) reply_if ();

  lcg_fisher_yates_shuffler_top #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (16)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (reply_if)
  );

  logic [15:0]    index_mirror [DEPTH];
  logic [31:0]    seed_mirror;
  lfys_pkg::out_t pending_replies [$];
  lfys_pkg::out_t want;
  int unsigned    mismatches;
  int unsigned    quiet_cycles;
  int unsigned    hold_count;
  bit             idle_en = 1'b1;
  bit             hold_request;

  always #5 clk_i = ~clk_i;

  function automatic lfys_pkg::out_t compute_reply(input lfys_pkg::in_t cmd);
    lfys_pkg::out_t reply;
    int unsigned    n;
    int unsigned    j;
    logic [63:0]    scaled;
    logic [15:0]    held;
    reply.read_value = '0;
    reply.seed_out   = cmd.seed_in;
    case (cmd.opcode)
      lfys_pkg::OP_LOAD: index_mirror[cmd.entry_addr] = cmd.entry_value;
      lfys_pkg::OP_READ: reply.read_value = index_mirror[cmd.entry_addr];
      lfys_pkg::OP_SHUFFLE: begin
        n = (cmd.count > DEPTH) ? DEPTH : cmd.count;
        seed_mirror = cmd.seed_in;
        for (int unsigned i = n - 1; n >= 2 && i >= 1; i--) begin
          seed_mirror = seed_mirror * SEED_MUL + SEED_INC;
          scaled = 64'(seed_mirror[30:0]) * 64'(i + 1);
          j = int'(scaled >> 31);
          held = index_mirror[i];
          index_mirror[i] = index_mirror[j];
          index_mirror[j] = held;
        end
        reply.seed_out = seed_mirror;
      end
      default: ;
    endcase
    return reply;
  endfunction

  function automatic lfys_pkg::in_t random_fields(input logic [1:0] op);
    lfys_pkg::in_t cmd;
    cmd.opcode      = op;
    cmd.entry_addr  = 10'($urandom_range(0, LOADED - 1));
    cmd.entry_value = 16'($urandom);
    cmd.count       = 11'($urandom);
    cmd.seed_in     = $urandom;
    return cmd;
  endfunction

  // mostly short shuffles, a few longer ones up to the whole loaded prefix
  function automatic logic [10:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 90) return 11'($urandom_range(0, 40));
    return 11'($urandom_range(41, LOADED));
  endfunction

  function automatic lfys_pkg::in_t random_command();
    lfys_pkg::in_t cmd;
    int unsigned   roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      cmd = random_fields(lfys_pkg::OP_LOAD);
    end else if (roll < 60) begin
      cmd = random_fields(lfys_pkg::OP_SHUFFLE);
      cmd.count = pick_count();
    end else if (roll < 95) begin
      cmd = random_fields(lfys_pkg::OP_READ);
    end else begin
      cmd = random_fields(OP_UNUSED);
    end
    return cmd;
  endfunction

  task automatic send_cmd(input lfys_pkg::in_t cmd);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= cmd;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    pending_replies.push_back(compute_reply(cmd));
  endtask

  task automatic drain_replies();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
  endtask

  task automatic test_directed();
    lfys_pkg::in_t cmd;
    logic [15:0]   patterns [8];
    patterns = '{16'h0000, 16'hffff, 16'h0001, 16'h8000,
                 16'h5555, 16'haaaa, 16'h1234, 16'h00ff};
    for (int a = 0; a < 8; a++) begin
      cmd = random_fields(lfys_pkg::OP_LOAD);
      cmd.entry_addr  = 10'(a);
      cmd.entry_value = patterns[a];
      send_cmd(cmd);
    end
    cmd = random_fields(lfys_pkg::OP_LOAD);
    cmd.entry_addr  = 10'h3ff;
    cmd.entry_value = 16'hffff;
    send_cmd(cmd);
    cmd = random_fields(lfys_pkg::OP_READ);
    cmd.entry_addr = 10'h3ff;
    send_cmd(cmd);
    send_cmd(random_fields(OP_UNUSED));
    // counts of zero and one run no step; counts of two and eight do
    cmd = random_fields(lfys_pkg::OP_SHUFFLE);
    cmd.count   = 11'd0;
    cmd.seed_in = 32'hffffffff;
    send_cmd(cmd);
    cmd.count   = 11'd1;
    cmd.seed_in = 32'h0;
    send_cmd(cmd);
    cmd.count   = 11'd2;
    cmd.seed_in = 32'h7fffffff;
    send_cmd(cmd);
    cmd.count   = 11'd8;
    cmd.seed_in = 32'h12345678;
    send_cmd(cmd);
    for (int a = 0; a < 8; a++) begin
      cmd = random_fields(lfys_pkg::OP_READ);
      cmd.entry_addr = 10'(a);
      send_cmd(cmd);
    end
    drain_replies();
  endtask

  task automatic test_prefix_store();
    lfys_pkg::in_t cmd;
    for (int a = 0; a < LOADED; a++) begin
      cmd = random_fields(lfys_pkg::OP_LOAD);
      cmd.entry_addr = 10'(a);
      send_cmd(cmd);
    end
    // whole prefix twice, one short of it
    cmd = random_fields(lfys_pkg::OP_SHUFFLE);
    cmd.count = 11'(LOADED);
    send_cmd(cmd);
    cmd.seed_in = 32'hffffffff;
    send_cmd(cmd);
    cmd.count   = 11'(LOADED - 1);
    cmd.seed_in = 32'h0;
    send_cmd(cmd);
    repeat (6) send_cmd(random_fields(lfys_pkg::OP_READ));
    drain_replies();
  endtask

  task automatic test_random_mix(input int unsigned num);
    repeat (num) send_cmd(random_command());
    drain_replies();
  endtask

  task automatic test_output_stall();
    hold_request = 1'b1;
    repeat (8) send_cmd(random_command());
    drain_replies();
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      repeat (5) send_cmd(random_command());
      drain_replies();
    end
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    test_random_mix(60);
  endtask

  initial begin
    reply_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        reply_if.ready <= 1'b0;
        for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(posedge clk_i);
        hold_request = 1'b0;
        reply_if.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        reply_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        reply_if.ready <= 1'b1;
      end else begin
        reply_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && reply_if.valid && reply_if.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: unexpected transaction read_value %h seed_out %h",
                 $time, reply_if.data.read_value, reply_if.data.seed_out);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (reply_if.data.read_value !== want.read_value) begin
          $display("%0t ns: read_value expected %h got %h",
                   $time, want.read_value, reply_if.data.read_value);
          mismatches++;
        end
        if (reply_if.data.seed_out !== want.seed_out) begin
          $display("%0t ns: seed_out expected %h got %h",
                   $time, want.seed_out, reply_if.data.seed_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (reply_if.valid && reply_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_prefix_store();
    test_random_mix(130);
    test_output_stall();
    test_sender_pause();
    test_no_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lfys_pkg.sv
rtl/lfys_chan_if.sv
rtl/lfys_ram.sv
rtl/lcg_fisher_yates_shuffler_top.sv
tb/sv/lcg_fisher_yates_shuffler_top_tb.sv
